[src/tse_pkg.sv]
// shared types and constants for the tls server name extractor
package tse_pkg;

    localparam int unsigned POS_W      = 17;
    localparam int unsigned SUM_W      = POS_W + 1;
    localparam int unsigned HS_END_W   = 25;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
    localparam logic [7:0]       REC_TYPE    = 8'd22;
    localparam logic [7:0]       HS_HELLO    = 8'd1;
    localparam logic [7:0]       RANDOM_LEN  = 8'd32;
    localparam logic [7:0]       REC_HDR_LEN = 8'd5;
    localparam logic [8:0]       CAP_MAX     = 9'd256;

    // configuration register indexes
    localparam logic CFG_MAX_RECORD_LENGTH = 1'b0;
    localparam logic CFG_HOST_CAPACITY     = 1'b1;

    // result kinds and status codes
    localparam logic       KIND_HOST   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;
    localparam logic [1:0] ST_NEED_MORE = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;

    typedef enum logic [3:0] {
        PH_REC,
        PH_HS_TYPE,
        PH_HS_LEN,
        PH_SKIP,
        PH_SID_LEN,
        PH_CS_LEN,
        PH_CM_LEN,
        PH_EXTS_LEN,
        PH_EXT_HDR,
        PH_SNI,
        PH_HOST,
        PH_DONE,
        PH_HS_BAD
    } t_phase;

    typedef enum logic [1:0] {
        V_PENDING,
        V_FOUND,
        V_REJECT,
        V_REC_REJECT
    } t_verdict;

    typedef struct packed {
        logic       kind;
        logic [7:0] host_byte;
        logic [1:0] status;
        logic [7:0] name_length;
        logic       last;
    } t_result;

endpackage

[src/tls_sni_extractor.sv]
// tls client hello parser that streams out the server name and a final status
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_stall      i_data_byte, i_last_of_buffer
//  result    out        o_valid / i_stall      o_kind, o_host_byte, o_status,
//                                              o_name_length, o_last
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
//  one byte request is taken per cycle while o_stall is low; its results appear from the next cycle
//  a byte that yields a host byte and the status takes two result queue slots
//  the four entry result queue raises o_stall once fewer than two slots are free
//  reset (i_rst_n low at a clock edge) clears parse state and queue pointers and loads the config defaults
//  a stalled result stays at the queue head until it is taken
module tls_sni_extractor
    import tse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte requests
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_buffer,
    // result requests
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_host_byte,
    output logic [1:0]  o_status,
    output logic [7:0]  o_name_length,
    output logic        o_last,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_max_record_length;
    logic [8:0]  r_host_capacity;

    // parse state
    logic [POS_W-1:0]    r_byte_position,  n_byte_position;
    logic [15:0]         r_record_length,  n_record_length;
    logic [HS_END_W-1:0] r_handshake_end,  n_handshake_end;
    t_phase              r_parse_phase,    n_parse_phase;
    logic [15:0]         r_field_remaining, n_field_remaining;
    logic [SUM_W-1:0]    r_extensions_end, n_extensions_end;
    logic [15:0]         r_extension_type, n_extension_type;
    logic [15:0]         r_extension_length, n_extension_length;
    logic [15:0]         r_host_remaining, n_host_remaining;
    t_verdict            r_verdict,        n_verdict;
    t_phase              r_skip_next,      n_skip_next;
    logic [2:0]          r_field_index,    n_field_index;
    logic [23:0]         r_field_value,    n_field_value;
    logic [7:0]          r_name_len,       n_name_len;

    // result queue
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;

    logic    w_acc;
    logic    w_pop;
    logic [1:0] w_push;
    t_result w_res0;
    t_result w_res1;
    t_result w_status_res;
    t_result w_host_res;
    logic [1:0] w_status;

    // position arithmetic, all from the current byte and registered state
    logic [SUM_W-1:0]    w_p_ext;
    logic [SUM_W-1:0]    w_pos_b;
    logic [15:0]         w_fv16;
    logic [SUM_W-1:0]    w_pos_fv;
    logic [23:0]         w_fv24;
    logic [HS_END_W-1:0] w_hs_end_new;
    logic [15:0]         w_ext_len_new;
    logic [SUM_W-1:0]    w_pos_ext;
    logic [15:0]         w_hr_new;
    logic [8:0]          w_cap;
    logic [HS_END_W-1:0] w_hs_end_cur;
    logic [POS_W-1:0]    w_rec_end;
    logic [16:0]         w_hr_plus_hdr;

    assign w_acc = i_valid && !o_stall;
    assign w_pop = o_valid && !i_stall;

    assign w_p_ext      = {1'b0, r_byte_position};
    assign w_pos_b      = w_p_ext + SUM_W'(1) + SUM_W'(i_data_byte);
    assign w_fv16       = {r_field_value[7:0], i_data_byte};
    assign w_pos_fv     = w_p_ext + SUM_W'(1) + SUM_W'(w_fv16);
    assign w_fv24       = {r_field_value[15:0], i_data_byte};
    assign w_hs_end_new = HS_END_W'(9) + HS_END_W'(w_fv24);
    assign w_ext_len_new = (r_field_index == 3'd3) ?
                           {r_extension_length[15:8], i_data_byte} : r_extension_length;
    assign w_pos_ext    = w_p_ext + SUM_W'(1) + SUM_W'(w_ext_len_new);
    assign w_hr_new     = {r_host_remaining[15:8], i_data_byte};
    assign w_hr_plus_hdr = 17'(w_hr_new) + 17'(REC_HDR_LEN);
    assign w_cap        = (r_host_capacity > CAP_MAX) ? CAP_MAX : r_host_capacity;
    assign w_hs_end_cur = r_handshake_end;

    // next parse state for one accepted byte
    always_comb begin
        n_byte_position    = (r_byte_position != POS_MAX) ?
                             r_byte_position + POS_W'(1) : r_byte_position;
        n_record_length    = r_record_length;
        n_handshake_end    = r_handshake_end;
        n_parse_phase      = r_parse_phase;
        n_field_remaining  = r_field_remaining;
        n_extensions_end   = r_extensions_end;
        n_extension_type   = r_extension_type;
        n_extension_length = r_extension_length;
        n_host_remaining   = r_host_remaining;
        n_verdict          = r_verdict;
        n_skip_next        = r_skip_next;
        n_field_index      = r_field_index;
        n_field_value      = r_field_value;
        n_name_len         = r_name_len;

        unique case (r_parse_phase) inside
            PH_REC: begin
                if (r_byte_position == POS_W'(0) && i_data_byte != REC_TYPE) begin
                    n_verdict     = V_REC_REJECT;
                    n_parse_phase = PH_DONE;
                end else if (r_byte_position == POS_W'(3)) begin
                    n_record_length = {i_data_byte, 8'h00};
                end else if (r_byte_position == POS_W'(4)) begin
                    n_record_length = {r_record_length[15:8], i_data_byte};
                    if (n_record_length == 16'd0 || n_record_length > r_max_record_length) begin
                        n_verdict     = V_REC_REJECT;
                        n_parse_phase = PH_DONE;
                    end else begin
                        n_parse_phase = PH_HS_TYPE;
                    end
                end
            end
            PH_HS_TYPE: begin
                if (i_data_byte != HS_HELLO) begin
                    n_verdict     = V_REJECT;
                    n_parse_phase = PH_HS_BAD;
                end else begin
                    n_parse_phase = PH_HS_LEN;
                    n_field_value = '0;
                end
            end
            PH_HS_LEN: begin
                n_field_value = w_fv24;
                if (r_byte_position >= POS_W'(8)) begin
                    n_handshake_end = w_hs_end_new;
                    if (HS_END_W'(11) + HS_END_W'(RANDOM_LEN) >= w_hs_end_new) begin
                        n_verdict     = V_REJECT;
                        n_parse_phase = PH_DONE;
                    end else begin
                        // version and random
                        n_field_index     = '0;
                        n_field_value     = '0;
                        n_field_remaining = 16'd2 + 16'(RANDOM_LEN);
                        n_skip_next       = PH_SID_LEN;
                        n_parse_phase     = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_field_remaining = r_field_remaining - 16'd1;
                if (n_field_remaining == 16'd0) begin
                    n_parse_phase = r_skip_next;
                end
            end
            PH_SID_LEN, PH_CM_LEN: begin
                if (HS_END_W'(w_pos_b) + HS_END_W'(2) > w_hs_end_cur) begin
                    n_verdict     = V_REJECT;
                    n_parse_phase = PH_DONE;
                end else begin
                    n_field_index     = '0;
                    n_field_value     = '0;
                    n_field_remaining = 16'(i_data_byte);
                    n_skip_next       = (r_parse_phase == PH_SID_LEN) ? PH_CS_LEN : PH_EXTS_LEN;
                    if (i_data_byte == 8'd0) begin
                        n_parse_phase = n_skip_next;
                    end else begin
                        n_parse_phase = PH_SKIP;
                    end
                end
            end
            PH_CS_LEN: begin
                n_field_value = 24'(w_fv16);
                n_field_index = r_field_index + 3'd1;
                if (n_field_index >= 3'd2) begin
                    if (HS_END_W'(w_pos_fv) + HS_END_W'(1) > w_hs_end_cur) begin
                        n_verdict     = V_REJECT;
                        n_parse_phase = PH_DONE;
                    end else begin
                        n_field_index     = '0;
                        n_field_value     = '0;
                        n_field_remaining = w_fv16;
                        n_skip_next       = PH_CM_LEN;
                        n_parse_phase     = (w_fv16 == 16'd0) ? PH_CM_LEN : PH_SKIP;
                    end
                end
            end
            PH_EXTS_LEN: begin
                n_field_value = 24'(w_fv16);
                n_field_index = r_field_index + 3'd1;
                if (n_field_index >= 3'd2) begin
                    n_extensions_end = w_pos_fv;
                    if (HS_END_W'(w_pos_fv) > w_hs_end_cur ||
                        w_p_ext + SUM_W'(5) > w_pos_fv) begin
                        n_verdict     = V_REJECT;
                        n_parse_phase = PH_DONE;
                    end else begin
                        n_field_index = '0;
                        n_parse_phase = PH_EXT_HDR;
                    end
                end
            end
            PH_EXT_HDR: begin
                case (r_field_index)
                    3'd0:    n_extension_type   = {i_data_byte, 8'h00};
                    3'd1:    n_extension_type   = {r_extension_type[15:8], i_data_byte};
                    3'd2:    n_extension_length = {i_data_byte, 8'h00};
                    default: n_extension_length = w_ext_len_new;
                endcase
                n_field_index = r_field_index + 3'd1;
                if (n_field_index >= 3'd4) begin
                    if (w_pos_ext > r_extensions_end) begin
                        n_verdict     = V_REJECT;
                        n_parse_phase = PH_DONE;
                    end else if (n_extension_type == 16'd0 &&
                                 w_ext_len_new >= 16'(REC_HDR_LEN)) begin
                        // server name extension with room for its list header
                        n_field_index = '0;
                        n_field_value = '0;
                        n_parse_phase = PH_SNI;
                    end else if (w_pos_ext + SUM_W'(4) > r_extensions_end) begin
                        n_verdict     = V_REJECT;
                        n_parse_phase = PH_DONE;
                    end else begin
                        n_field_index     = '0;
                        n_field_value     = '0;
                        n_field_remaining = w_ext_len_new;
                        n_skip_next       = PH_EXT_HDR;
                        n_parse_phase     = (w_ext_len_new == 16'd0) ? PH_EXT_HDR : PH_SKIP;
                    end
                end
            end
            PH_SNI: begin
                case (r_field_index)
                    3'd2:    n_field_value    = 24'(i_data_byte);
                    3'd3:    n_host_remaining = {i_data_byte, 8'h00};
                    3'd4:    n_host_remaining = w_hr_new;
                    default: ;
                endcase
                n_field_index = r_field_index + 3'd1;
                if (n_field_index >= 3'd5) begin
                    if (r_field_value == 24'd0 && w_hr_new != 16'd0 &&
                        w_hr_plus_hdr <= 17'(r_extension_length) &&
                        w_hr_new < 16'(w_cap)) begin
                        n_verdict     = V_FOUND;
                        n_name_len    = w_hr_new[7:0];
                        n_parse_phase = PH_HOST;
                    end else begin
                        n_verdict     = V_REJECT;
                        n_parse_phase = PH_DONE;
                    end
                end
            end
            PH_HOST: begin
                n_host_remaining = r_host_remaining - 16'd1;
                if (n_host_remaining == 16'd0) begin
                    n_parse_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    assign w_rec_end = POS_W'(REC_HDR_LEN) + POS_W'(n_record_length);

    // results for one accepted byte: host byte first, then the status
    always_comb begin
        if (n_byte_position < POS_W'(REC_HDR_LEN)) begin
            w_status = ST_NEED_MORE;
        end else if (n_verdict == V_REC_REJECT) begin
            w_status = ST_REJECTED;
        end else if (n_byte_position < w_rec_end) begin
            w_status = ST_NEED_MORE;
        end else if (n_parse_phase == PH_HS_BAD) begin
            w_status = ST_REJECTED;
        end else if (n_parse_phase == PH_HS_TYPE || n_parse_phase == PH_HS_LEN) begin
            w_status = ST_NEED_MORE;
        end else if (n_handshake_end > HS_END_W'(w_rec_end)) begin
            // handshake runs past the buffered record
            w_status = ST_NEED_MORE;
        end else if (n_verdict == V_FOUND) begin
            w_status = ST_FOUND;
        end else if (n_verdict == V_REJECT) begin
            w_status = ST_REJECTED;
        end else begin
            w_status = ST_NEED_MORE;
        end

        w_host_res.kind        = KIND_HOST;
        w_host_res.host_byte   = i_data_byte;
        w_host_res.status      = ST_NEED_MORE;
        w_host_res.name_length = 8'd0;
        w_host_res.last        = 1'b0;

        w_status_res.kind        = KIND_STATUS;
        w_status_res.host_byte   = 8'd0;
        w_status_res.status      = w_status;
        w_status_res.name_length = (w_status == ST_FOUND) ? n_name_len : 8'd0;
        w_status_res.last        = 1'b1;

        if (r_parse_phase == PH_HOST) begin
            w_res0 = w_host_res;
            w_res1 = w_status_res;
            w_push = i_last_of_buffer ? 2'd2 : 2'd1;
        end else begin
            w_res0 = w_status_res;
            w_res1 = w_status_res;
            w_push = i_last_of_buffer ? 2'd1 : 2'd0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_record_length <= 16'd16384;
            r_host_capacity     <= CAP_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_RECORD_LENGTH: r_max_record_length <= i_cfg_data;
                CFG_HOST_CAPACITY:     r_host_capacity     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // parse state; the last byte of a buffer returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_last_of_buffer)) begin
            r_byte_position    <= '0;
            r_record_length    <= '0;
            r_handshake_end    <= '0;
            r_parse_phase      <= PH_REC;
            r_field_remaining  <= '0;
            r_extensions_end   <= '0;
            r_extension_type   <= '0;
            r_extension_length <= '0;
            r_host_remaining   <= '0;
            r_verdict          <= V_PENDING;
            r_skip_next        <= PH_REC;
            r_field_index      <= '0;
            r_field_value      <= '0;
            r_name_len         <= '0;
        end else if (w_acc) begin
            r_byte_position    <= n_byte_position;
            r_record_length    <= n_record_length;
            r_handshake_end    <= n_handshake_end;
            r_parse_phase      <= n_parse_phase;
            r_field_remaining  <= n_field_remaining;
            r_extensions_end   <= n_extensions_end;
            r_extension_type   <= n_extension_type;
            r_extension_length <= n_extension_length;
            r_host_remaining   <= n_host_remaining;
            r_verdict          <= n_verdict;
            r_skip_next        <= n_skip_next;
            r_field_index      <= n_field_index;
            r_field_value      <= n_field_value;
            r_name_len         <= n_name_len;
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (w_acc && w_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_acc && w_push == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= w_res1;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_acc) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(w_push);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (w_acc ? FIFO_CW'(w_push) : FIFO_CW'(0))
                               - (w_pop ? FIFO_CW'(1) : FIFO_CW'(0));
        end
    end

    // hold off byte requests unless two result slots are free
    assign o_stall = (r_count > FIFO_CW'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != FIFO_CW'(0));

    assign o_kind        = r_fifo[r_rd_ptr].kind;
    assign o_host_byte   = r_fifo[r_rd_ptr].host_byte;
    assign o_status      = r_fifo[r_rd_ptr].status;
    assign o_name_length = r_fifo[r_rd_ptr].name_length;
    assign o_last        = r_fifo[r_rd_ptr].last;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // last byte of a buffer clears the parser
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last_of_buffer) |=>
            (r_parse_phase == PH_REC && r_byte_position == POS_W'(0)))
        else $error("parser not cleared after last byte");

    // host bytes only stream once the name is accepted
    a_host_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_parse_phase == PH_HOST) |-> (r_verdict == V_FOUND && r_name_len != 8'd0))
        else $error("host phase without accepted name");

    // status results close the buffer, host bytes never do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind == KIND_STATUS)))
        else $error("last flag disagrees with result kind");

endmodule
